### rtl/core/crbd_pkg.sv
// shared types and constants for the cat reply band decoder
package crbd_pkg;

	localparam int LINE_DEPTH = 64;
	localparam int IDX_W      = $clog2(LINE_DEPTH);
	localparam int FIELD_POS  = 5;
	localparam int FIELD_LEN  = 5;
	localparam int KHZ_W      = 17;
	localparam int PADDR_W    = 3;

	localparam logic [7:0] CHAR_I    = 8'h49;
	localparam logic [7:0] CHAR_F    = 8'h46;
	localparam logic [7:0] CHAR_SEMI = 8'h3B;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_POLL = 1'b1;

	localparam logic [PADDR_W-1:0] ADDR_MISS_LIMIT = 3'd0;
	localparam logic [3:0]         MISS_LIMIT_RST  = 4'd3;

	localparam logic [3:0] BAND_NONE = 4'd0;
	localparam logic [3:0] BAND_160M = 4'd1;
	localparam logic [3:0] BAND_80M  = 4'd2;
	localparam logic [3:0] BAND_40M  = 4'd3;
	localparam logic [3:0] BAND_20M  = 4'd4;
	localparam logic [3:0] BAND_15M  = 4'd5;
	localparam logic [3:0] BAND_10M  = 4'd6;
	localparam logic [3:0] BAND_30M  = 4'd7;
	localparam logic [3:0] BAND_17M  = 4'd8;
	localparam logic [3:0] BAND_12M  = 4'd9;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       band_update;
		logic [3:0] band;
		logic       led_toggle;
	} result_t;

	typedef struct packed {
		logic       if_hit;
		logic       field_ok;
		logic [3:0] band;
	} field_res_t;

endpackage

### rtl/core/crbd_field.sv
// reply header check, frequency field conversion and band lookup
module crbd_field
	import crbd_pkg::*;
(
	input  logic [1:0][7:0]           hdr,
	input  logic [FIELD_LEN-1:0][7:0] fld,
	output field_res_t                res
);

	logic [KHZ_W-1:0] khz;
	logic             done;
	logic             ok;

	function automatic logic [3:0] map_band(input logic [KHZ_W-1:0] f);
		logic [3:0] b;
		b = BAND_NONE;
		if (f >= 17'd1810 && f <= 17'd2000)        b = BAND_160M;
		else if (f >= 17'd3500 && f <= 17'd3800)   b = BAND_80M;
		else if (f >= 17'd7000 && f <= 17'd7200)   b = BAND_40M;
		else if (f >= 17'd14000 && f <= 17'd14350) b = BAND_20M;
		else if (f >= 17'd21000 && f <= 17'd21450) b = BAND_15M;
		else if (f >= 17'd28000 && f <= 17'd29700) b = BAND_10M;
		else if (f >= 17'd10100 && f <= 17'd10150) b = BAND_30M;
		else if (f >= 17'd18068 && f <= 17'd18168) b = BAND_17M;
		else if (f >= 17'd24890 && f <= 17'd25140) b = BAND_12M;
		return b;
	endfunction

	// digits are taken up to the first zero byte; a non-digit byte before it marks the field bad
	always_comb begin
		khz  = '0;
		done = 1'b0;
		ok   = 1'b1;
		for (int i = 0; i < FIELD_LEN; i++) begin
			if (!done) begin
				if (fld[i] == 8'h00) begin
					done = 1'b1;
				end else if (fld[i] < CHAR_ZERO || fld[i] > CHAR_NINE) begin
					ok   = 1'b0;
					done = 1'b1;
				end else begin
					khz = KHZ_W'(khz * 17'd10 + KHZ_W'(fld[i] - CHAR_ZERO));
				end
			end
		end
	end

	assign res.if_hit   = (hdr[0] == CHAR_I) && (hdr[1] == CHAR_F);
	assign res.field_ok = ok;
	assign res.band     = map_band(khz);

endmodule

### rtl/core/cat_reply_band_decoder_unit.sv
// Decodes transceiver CAT replies and poll ticks into band selections. One request is
// accepted every clock cycle unless stalled; each gives exactly one result after the
// input register and the result register. The line index, miss counter and the stored
// line bytes are updated as a request leaves the input register, so back-to-back requests
// see each other's effects in order. Only the line positions that the decoder reads
// (header and frequency field) are held in flops; the rest of the line is never looked at.
module cat_reply_band_decoder_unit
	import crbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               res_valid,
	input  logic               res_stall,
	output result_t            res
);

	logic [3:0]                miss_limit_q;
	logic [3:0]                miss_q;
	logic [IDX_W-1:0]          widx_q;
	logic [1:0][7:0]           hdr_q;
	logic [FIELD_LEN-1:0][7:0] fld_q;

	logic                      valid_s1;
	item_t                     item_s1;

	logic                      adv;
	logic                      is_byte;
	logic [1:0][7:0]           hdr_v;
	logic [FIELD_LEN-1:0][7:0] fld_v;
	field_res_t                fres;
	logic [3:0]                miss_inc;
	logic                      semi;
	result_t                   res_d;
	logic [3:0]                miss_d;
	logic [IDX_W-1:0]          widx_d;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_MISS_LIMIT) ? {28'd0, miss_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_limit_q <= MISS_LIMIT_RST;
		end else if (psel && penable && pwrite && paddr == ADDR_MISS_LIMIT) begin
			miss_limit_q <= pwdata[3:0];
		end
	end

	// handshake
	assign adv        = valid_s1 && (!res_valid || !res_stall);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// line as seen with this byte already written
	assign is_byte = (item_s1.func == FUNC_BYTE);

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			hdr_v[p] = (is_byte && widx_q == IDX_W'(p)) ? item_s1.rx_byte : hdr_q[p];
		end
		for (int p = 0; p < FIELD_LEN; p++) begin
			fld_v[p] = (is_byte && widx_q == IDX_W'(FIELD_POS + p)) ?
				item_s1.rx_byte : fld_q[p];
		end
	end

	crbd_field u_field (
		.hdr (hdr_v),
		.fld (fld_v),
		.res (fres)
	);

	assign miss_inc = miss_q + 4'd1;
	assign semi     = is_byte && (item_s1.rx_byte == CHAR_SEMI);

	always_comb begin
		res_d  = '0;
		miss_d = miss_q;
		widx_d = widx_q;
		if (!is_byte) begin
			miss_d = miss_inc;
			if (miss_inc >= miss_limit_q) begin
				res_d.band_update = 1'b1;
				res_d.band        = BAND_NONE;
				miss_d            = 4'd0;
			end
		end else if (semi) begin
			widx_d = '0;
			miss_d = 4'd0;
			if (fres.if_hit) begin
				res_d.led_toggle = 1'b1;
				if (fres.field_ok) begin
					res_d.band_update = 1'b1;
					res_d.band        = fres.band;
				end
			end
		end else if (widx_q == IDX_W'(LINE_DEPTH - 1)) begin
			widx_d = '0;
		end else begin
			widx_d = widx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_q <= 4'd0;
			widx_q <= '0;
			hdr_q  <= '0;
			fld_q  <= '0;
		end else if (adv) begin
			miss_q <= miss_d;
			widx_q <= widx_d;
			hdr_q  <= hdr_v;
			fld_q  <= fld_v;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (!res_valid || !res_stall) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res <= res_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_band_needs_update: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.band_update |-> res.band == BAND_NONE)
		else $error("band set without update");

	a_band_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.band <= BAND_12M)
		else $error("band code out of range");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		widx_q <= IDX_W'(LINE_DEPTH - 1))
		else $error("write index beyond line depth");

	a_semi_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && semi |=> widx_q == '0 && miss_q == 4'd0)
		else $error("line end did not reset index and miss count");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res_valid && res_stall)
		else $error("input stalled with room downstream");
`endif

endmodule
